FILE: rtl/gebf_pkg.sv
// ----------------------------------------------------------------------------
// gebf_pkg
// Shared types and constants of the gradient edge blackout filter.
// ----------------------------------------------------------------------------
`default_nettype none

package gebf_pkg;

   // channel field widths
   localparam int CHAN_W     = 8;
   localparam int PIX_W      = 4 * CHAN_W;
   localparam int COORD_W    = 12;
   localparam int THRESH_W   = 11;
   localparam int GEOM_W     = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   // frame height limit
   localparam logic [GEOM_W-1:0] MAX_HEIGHT = 13'd4096;

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_WIDTH     = 2'd1,
      CSR_HEIGHT    = 2'd2
   } csr_index_type;

   // position and class of a pixel on its way through the compute stage
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               inner;
      logic               border;
   } tag_type;

   // one result item
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
      logic [CHAN_W-1:0]  alpha;
      logic               last;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/gebf_if.sv
// ----------------------------------------------------------------------------
// gebf channel interfaces
// Valid/ready channels for pixels in, results out and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface gebf_req_if;
   import gebf_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] in_red;
   logic [CHAN_W-1:0] in_green;
   logic [CHAN_W-1:0] in_blue;
   logic [CHAN_W-1:0] in_alpha;
   modport source (output valid, output in_red, output in_green, output in_blue,
                   output in_alpha, input ready);
   modport sink   (input valid, input in_red, input in_green, input in_blue,
                   input in_alpha, output ready);
endinterface

interface gebf_rsp_if;
   import gebf_pkg::*;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] out_x;
   logic [COORD_W-1:0] out_y;
   logic [CHAN_W-1:0]  out_red;
   logic [CHAN_W-1:0]  out_green;
   logic [CHAN_W-1:0]  out_blue;
   logic [CHAN_W-1:0]  out_alpha;
   logic               run_last;
   modport source (output valid, output out_x, output out_y, output out_red,
                   output out_green, output out_blue, output out_alpha,
                   output run_last, input ready);
   modport sink   (input valid, input out_x, input out_y, input out_red,
                   input out_green, input out_blue, input out_alpha,
                   input run_last, output ready);
endinterface

interface gebf_csr_if;
   import gebf_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/gradient_edge_blackout_filter.sv
// A result passes the compute stage register and then the result queue before it leaves.
// Throughput: one pixel per cycle; the input stalls while a pixel waits in compute and the
// four-entry result queue holds three or more, as when pixels yield two results in a row.
// Row stores are two single-port-read memories of MAX_WIDTH words, one read and one
// write per pixel; reset clears counters, registers, window and queue, not the row stores.
// ----------------------------------------------------------------------------
// gradient_edge_blackout_filter
// 3x3 gradient threshold edge blackout over a raster RGBA pixel stream.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_edge_blackout_filter #(
   parameter int MAX_WIDTH = 4096
) (
   input  wire logic   clock,
   input  wire logic   reset,
   gebf_req_if.sink    req_chan,
   gebf_rsp_if.source  rsp_chan,
   gebf_csr_if.sink    csr_chan
);
   import gebf_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int CW = ((XW > GEOM_W) ? XW : GEOM_W) + 1;

   // configuration registers
   logic [THRESH_W-1:0] thresh_ff;
   logic [GEOM_W-1:0]   width_ff;
   logic [GEOM_W-1:0]   height_ff;

   // position of the next pixel
   logic [XW-1:0]       col_ff;
   logic [XW-1:0]       col_in;
   logic [COORD_W-1:0]  row_ff;
   logic [COORD_W-1:0]  row_in;

   // compute stage
   logic                s1_valid_ff;
   tag_type             s1_tag_ff;
   logic [XW-1:0]       s1_addr_ff;
   logic [PIX_W-1:0]    s1_pix_ff;

   logic                csr_write;
   logic                geom_write;
   logic                accept;
   logic                s1_go;
   logic                room;
   logic [CW-1:0]       w_eff;
   logic [GEOM_W-1:0]   h_eff;
   logic [CW-1:0]       x_ext;
   logic                last_col;
   logic                last_row;
   tag_type             tag_new;
   logic [PIX_W-1:0]    pix_new;
   logic [PIX_W-1:0]    above_rd;
   logic [PIX_W-1:0]    two_above_rd;
   logic [PIX_W-1:0]    centre;
   logic                is_edge;
   logic [PIX_W-1:0]    inner_pix;
   rsp_type             res_inner;
   rsp_type             res_border;
   rsp_type             push_first;
   logic [1:0]          push_num;

   // handshakes
   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid;
   assign s1_go          = s1_valid_ff && room;
   assign req_chan.ready = !s1_valid_ff || room;
   assign accept         = req_chan.valid && req_chan.ready;

   // register writes
   always_comb begin
      geom_write = 1'b0;
      if (csr_write) begin
         unique case (csr_chan.index) inside
            CSR_WIDTH, CSR_HEIGHT: geom_write = 1'b1;
            default:               geom_write = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= '0;
         width_ff  <= 13'd4096;
         height_ff <= 13'd4096;
      end else if (csr_write) begin
         unique case (csr_chan.index)
            CSR_THRESHOLD: thresh_ff <= csr_chan.data[THRESH_W-1:0];
            CSR_WIDTH:     width_ff  <= csr_chan.data;
            CSR_HEIGHT:    height_ff <= csr_chan.data;
            default:       thresh_ff <= thresh_ff;
         endcase
      end
   end

   // effective geometry
   always_comb begin
      if (width_ff == '0) begin
         w_eff = CW'(1);
      end else if (CW'(width_ff) > CW'(MAX_WIDTH)) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = CW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = GEOM_W'(1);
      end else if (height_ff > MAX_HEIGHT) begin
         h_eff = MAX_HEIGHT;
      end else begin
         h_eff = height_ff;
      end
   end

   // classify the incoming pixel and step the raster position
   always_comb begin
      x_ext    = CW'(col_ff);
      last_col = (x_ext + CW'(1)) >= w_eff;
      last_row = (GEOM_W'(row_ff) + GEOM_W'(1)) >= h_eff;

      tag_new.x      = x_ext[COORD_W-1:0];
      tag_new.y      = row_ff;
      tag_new.inner  = (x_ext >= CW'(2)) && (row_ff >= COORD_W'(2));
      tag_new.border = (col_ff == '0) || (row_ff == '0) || last_col || last_row;

      pix_new = {req_chan.in_alpha, req_chan.in_blue, req_chan.in_green, req_chan.in_red};

      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_ff + COORD_W'(1);
      end else begin
         col_in = col_ff + XW'(1);
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (geom_write) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // compute stage: holds the pixel while its row store words are read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_tag_ff  <= tag_new;
         s1_addr_ff <= col_ff;
         s1_pix_ff  <= pix_new;
      end
   end

   // row stores: read on transfer, written back when the pixel leaves compute
   gebf_line_mem #(
      .Depth (MAX_WIDTH)
   ) u_above (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (above_rd),
      .wr_en   (s1_go),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_pix_ff)
   );

   gebf_line_mem #(
      .Depth (MAX_WIDTH)
   ) u_two_above (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (two_above_rd),
      .wr_en   (s1_go),
      .wr_addr (s1_addr_ff),
      .wr_data (above_rd)
   );

   // window and gradient test
   gebf_grad u_grad (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (s1_go),
      .col_top   (two_above_rd),
      .col_mid   (above_rd),
      .col_bot   (s1_pix_ff),
      .threshold (thresh_ff),
      .centre    (centre),
      .is_edge   (is_edge)
   );

   // build the results of this pixel
   always_comb begin
      inner_pix = is_edge ? {centre[PIX_W-1 -: CHAN_W], {(PIX_W-CHAN_W){1'b0}}} : centre;

      res_inner.x     = s1_tag_ff.x - COORD_W'(1);
      res_inner.y     = s1_tag_ff.y - COORD_W'(1);
      res_inner.red   = inner_pix[0*CHAN_W +: CHAN_W];
      res_inner.green = inner_pix[1*CHAN_W +: CHAN_W];
      res_inner.blue  = inner_pix[2*CHAN_W +: CHAN_W];
      res_inner.alpha = inner_pix[3*CHAN_W +: CHAN_W];
      res_inner.last  = !s1_tag_ff.border;

      res_border.x     = s1_tag_ff.x;
      res_border.y     = s1_tag_ff.y;
      res_border.red   = '0;
      res_border.green = '0;
      res_border.blue  = '0;
      res_border.alpha = '0;
      res_border.last  = 1'b1;

      push_first = s1_tag_ff.inner ? res_inner : res_border;
      push_num   = s1_go ? (2'(s1_tag_ff.inner) + 2'(s1_tag_ff.border)) : 2'd0;
   end

   // result queue
   gebf_rsp_fifo u_rsp_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_num    (push_num),
      .push_first  (push_first),
      .push_second (res_border),
      .room        (room),
      .rsp_chan    (rsp_chan)
   );

endmodule

`default_nettype wire

FILE: rtl/gebf_line_mem.sv
// ----------------------------------------------------------------------------
// gebf_line_mem
// One row store: synchronous memory with registered read and write bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module gebf_line_mem #(
   parameter int Depth = 4096
) (
   input  wire logic                         clock,
   input  wire logic                         rd_en,
   input  wire logic [$clog2(Depth)-1:0]     rd_addr,
   output logic [gebf_pkg::PIX_W-1:0]        rd_data,
   input  wire logic                         wr_en,
   input  wire logic [$clog2(Depth)-1:0]     wr_addr,
   input  wire logic [gebf_pkg::PIX_W-1:0]   wr_data
);
   import gebf_pkg::*;

   logic [PIX_W-1:0] mem_ff [Depth];
   logic [PIX_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, a write to the same entry in the same cycle is passed through
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/gebf_grad.sv
// ----------------------------------------------------------------------------
// gebf_grad
// 3x3 window columns and the gradient threshold test on the window centre.
// ----------------------------------------------------------------------------
`default_nettype none

module gebf_grad (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            shift_en,
   input  wire logic [gebf_pkg::PIX_W-1:0]      col_top,
   input  wire logic [gebf_pkg::PIX_W-1:0]      col_mid,
   input  wire logic [gebf_pkg::PIX_W-1:0]      col_bot,
   input  wire logic [gebf_pkg::THRESH_W-1:0]   threshold,
   output logic [gebf_pkg::PIX_W-1:0]           centre,
   output logic                                 is_edge
);
   import gebf_pkg::*;

   localparam int DIFF_W = 10;
   localparam int SUM_W  = 11;

   // [0..2]: column two back, rows top..bottom ; [3..5]: column one back
   logic [PIX_W-1:0] win_ff [6];

   logic [SUM_W-1:0] sum_hv;
   logic [SUM_W-1:0] sum_diag;

   // summed absolute difference over red, green and blue
   function automatic logic [DIFF_W-1:0] absdiff3(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
      logic [DIFF_W-1:0] s;
      logic [CHAN_W-1:0] p;
      logic [CHAN_W-1:0] q;
      s = '0;
      for (int k = 0; k < 3; k++) begin
         p = a[k*CHAN_W +: CHAN_W];
         q = b[k*CHAN_W +: CHAN_W];
         s = s + DIFF_W'((p > q) ? (p - q) : (q - p));
      end
      return s;
   endfunction

   // window shift, one column per transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (shift_en) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= col_top;
         win_ff[4] <= col_mid;
         win_ff[5] <= col_bot;
      end
   end

   // left/right plus up/down, and the two diagonals
   always_comb begin
      sum_hv   = SUM_W'(absdiff3(win_ff[1], col_mid)) +
                 SUM_W'(absdiff3(win_ff[3], win_ff[5]));
      sum_diag = SUM_W'(absdiff3(win_ff[0], col_bot)) +
                 SUM_W'(absdiff3(col_top, win_ff[2]));
   end

   assign is_edge = (sum_hv > threshold) || (sum_diag > threshold);
   assign centre  = win_ff[4];

endmodule

`default_nettype wire

FILE: rtl/gebf_rsp_fifo.sv
// ----------------------------------------------------------------------------
// gebf_rsp_fifo
// Four-entry result queue taking up to two results per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gebf_rsp_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [1:0]           push_num,
   input  gebf_pkg::rsp_type         push_first,
   input  gebf_pkg::rsp_type         push_second,
   output logic                      room,
   gebf_rsp_if.source                rsp_chan
);
   import gebf_pkg::*;

   rsp_type    entry_ff [4];
   logic [1:0] wr_ptr_ff;
   logic [1:0] wr_ptr_in;
   logic [1:0] rd_ptr_ff;
   logic [1:0] rd_ptr_in;
   logic [2:0] count_ff;
   logic [2:0] count_in;
   logic       pop;
   rsp_type    head;

   assign pop  = rsp_chan.valid && rsp_chan.ready;
   assign room = (count_ff <= 3'd2);

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_num;
      rd_ptr_in = rd_ptr_ff + 2'(pop);
      count_in  = count_ff + 3'(push_num) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry writes
   always_ff @(posedge clock) begin
      if (push_num != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_first;
      end
      if (push_num == 2'd2) begin
         entry_ff[wr_ptr_ff + 2'd1] <= push_second;
      end
   end

   // head of queue onto the result channel
   assign head               = entry_ff[rd_ptr_ff];
   assign rsp_chan.valid     = (count_ff != 3'd0);
   assign rsp_chan.out_x     = head.x;
   assign rsp_chan.out_y     = head.y;
   assign rsp_chan.out_red   = head.red;
   assign rsp_chan.out_green = head.green;
   assign rsp_chan.out_blue  = head.blue;
   assign rsp_chan.out_alpha = head.alpha;
   assign rsp_chan.run_last  = head.last;

endmodule

`default_nettype wire

FILE: test/gradient_edge_blackout_filter_tb.sv
// ----------------------------------------------------------------------------
// gradient_edge_blackout_filter_tb
// Self-checking bench for the edge blackout filter. Pixels go in over the
// request channel while a behavioral copy of the filter predicts every
// result; results coming back are compared field by field in order. Short
// directed frames come first, then random frames over many geometries,
// thresholds and image styles; random stalls on both channels run in all but the closing stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module gradient_edge_blackout_filter_tb;

   import gebf_pkg::*;

   localparam int FRAME_MAX_W   = 4096;
   localparam int SETTLE_CYCLES = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum logic [1:0] {
      STYLE_NOISE,
      STYLE_SMOOTH,
      STYLE_SPLIT
   } pixel_style_type;

   logic clock;
   logic reset;

   gebf_req_if req_bus ();
   gebf_rsp_if rsp_bus ();
   gebf_csr_if csr_bus ();

   gradient_edge_blackout_filter u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // filter state as predicted
   logic [PIX_W-1:0]    rows_above     [FRAME_MAX_W] = '{default: '0};
   logic [PIX_W-1:0]    rows_two_above [FRAME_MAX_W] = '{default: '0};
   logic [PIX_W-1:0]    win_cols       [6]           = '{default: '0};
   int unsigned         col_count  = 0;
   int unsigned         row_count  = 0;
   logic [THRESH_W-1:0] thresh_reg = '0;
   logic [GEOM_W-1:0]   width_reg  = 13'd4096;
   logic [GEOM_W-1:0]   height_reg = 13'd4096;

   rsp_type awaited_pixels [$];

   int mismatches    = 0;
   int pixels_sent   = 0;
   int src_gap_pct   = 0;
   int snk_stall_pct = 0;

   // image content controls
   pixel_style_type cur_style  = STYLE_NOISE;
   logic [PIX_W-1:0] base_color = '0;
   logic [PIX_W-1:0] alt_color  = '0;
   int unsigned     noise_mag  = 0;
   int unsigned     split_kind = 0;
   int unsigned     split_pos  = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("gradient_edge_blackout_filter regression: fail");
      $finish;
   end

   // sum of absolute channel differences over red, green and blue
   function automatic int unsigned color_distance(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
      int unsigned s;
      int unsigned p;
      int unsigned q;
      s = 0;
      for (int k = 0; k < 3; k++) begin
         p = a[8*k +: 8];
         q = b[8*k +: 8];
         s += (p > q) ? (p - q) : (q - p);
      end
      return s;
   endfunction

   // geometry register as the block uses it: zero acts as one, clipped at max
   function automatic int unsigned effective_extent(input logic [GEOM_W-1:0] value,
                                                    input int unsigned limit);
      if (value == 0)
         return 1;
      if (value > limit)
         return limit;
      return value;
   endfunction

   // expected results for one accepted pixel, then state update
   task automatic predict_blackout(input logic [PIX_W-1:0] cur);
      int unsigned      w;
      int unsigned      h;
      int unsigned      x;
      int unsigned      y;
      int unsigned      s1;
      int unsigned      s2;
      logic [PIX_W-1:0] ctop;
      logic [PIX_W-1:0] cmid;
      logic [PIX_W-1:0] shade;
      logic             border;
      logic             inner;
      rsp_type          item;
      w = effective_extent(width_reg, FRAME_MAX_W);
      h = effective_extent(height_reg, MAX_HEIGHT);
      x = col_count;
      y = row_count;
      ctop = rows_two_above[x];
      cmid = rows_above[x];
      border = (x == 0) || (y == 0) || (x + 1 >= w) || (y + 1 >= h);
      inner = (x >= 2) && (y >= 2);

      // interior pixel one up and one left of the current input
      if (inner) begin
         s1 = color_distance(win_cols[1], cmid) + color_distance(win_cols[3], win_cols[5]);
         s2 = color_distance(win_cols[0], cur) + color_distance(ctop, win_cols[2]);
         shade = win_cols[4];
         if (s1 > thresh_reg || s2 > thresh_reg)
            shade = {win_cols[4][31:24], 24'h0};
         item.x     = COORD_W'(x - 1);
         item.y     = COORD_W'(y - 1);
         item.red   = shade[7:0];
         item.green = shade[15:8];
         item.blue  = shade[23:16];
         item.alpha = shade[31:24];
         item.last  = !border;
         awaited_pixels.push_back(item);
      end

      // border pixels come out black with zero alpha
      if (border) begin
         item = '0;
         item.x    = COORD_W'(x);
         item.y    = COORD_W'(y);
         item.last = 1'b1;
         awaited_pixels.push_back(item);
      end

      // shift the window and the row stores
      win_cols[0] = win_cols[3];
      win_cols[1] = win_cols[4];
      win_cols[2] = win_cols[5];
      win_cols[3] = ctop;
      win_cols[4] = cmid;
      win_cols[5] = cur;
      rows_two_above[x] = cmid;
      rows_above[x] = cur;

      // raster position of the next pixel
      if (x + 1 >= w) begin
         col_count = 0;
         row_count = (y + 1 >= h) ? 0 : y + 1;
      end else begin
         col_count = x + 1;
      end
   endtask

   // one register write, with valid dropped after the transfer
   task automatic write_register(input logic [CSR_IDX_W-1:0]  idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      if (idx == CSR_THRESHOLD) begin
         thresh_reg = value[THRESH_W-1:0];
      end else if (idx == CSR_WIDTH) begin
         width_reg = value;
         col_count = 0;
         row_count = 0;
      end else if (idx == CSR_HEIGHT) begin
         height_reg = value;
         col_count = 0;
         row_count = 0;
      end
      @(posedge clock);
   endtask

   // one pixel transfer, with an occasional gap in front of it
   task automatic send_pixel(input logic [PIX_W-1:0] px);
      if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.in_red   <= px[7:0];
      req_bus.in_green <= px[15:8];
      req_bus.in_blue  <= px[23:16];
      req_bus.in_alpha <= px[31:24];
      do @(posedge clock); while (!req_bus.ready);
      predict_blackout(px);
      pixels_sent++;
   endtask

   task automatic stop_pixels();
      req_bus.valid <= 1'b0;
   endtask

   // all results back and the pipeline quiet
   task automatic wait_drained();
      while (awaited_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // next pixel of the current image style at the current raster position
   function automatic logic [PIX_W-1:0] make_pixel();
      logic [PIX_W-1:0] px;
      int unsigned      v;
      logic             far_side;
      if (cur_style == STYLE_NOISE)
         return $urandom();
      case (split_kind)
         0:       far_side = col_count >= split_pos;
         1:       far_side = row_count >= split_pos;
         default: far_side = col_count + row_count >= split_pos;
      endcase
      px = (cur_style == STYLE_SPLIT && far_side) ? alt_color : base_color;
      for (int k = 0; k < 3; k++) begin
         v = px[8*k +: 8] + $urandom_range(0, noise_mag);
         px[8*k +: 8] = (v > 255) ? 8'hFF : v[7:0];
      end
      px[31:24] = 8'($urandom_range(0, 255));
      return px;
   endfunction

   function automatic int idle_share();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 5;
         2:       return 25;
         default: return 60;
      endcase
   endfunction

   // mostly small extents, now and then the limits and beyond
   function automatic logic [CSR_DATA_W-1:0] pick_extent();
      case ($urandom_range(0, 19))
         0:       return 13'd0;
         1:       return 13'd1;
         2:       return 13'd2;
         3:       return 13'd3;
         4:       return 13'd4096;
         5:       return 13'd8191;
         6:       return CSR_DATA_W'($urandom_range(4097, 8191));
         7:       return CSR_DATA_W'($urandom_range(13, 4095));
         default: return CSR_DATA_W'($urandom_range(3, 12));
      endcase
   endfunction

   // result sink with bursts of back pressure
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (snk_stall_pct != 0 && $urandom_range(0, 99) < snk_stall_pct) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // compare every result transfer with the oldest prediction
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_pixels.size() == 0) begin
            $error("unexpected result at x=%0d y=%0d", rsp_bus.out_x, rsp_bus.out_y);
            mismatches++;
         end else begin
            want = awaited_pixels.pop_front();
            compare_field("out_x", want.x, rsp_bus.out_x);
            compare_field("out_y", want.y, rsp_bus.out_y);
            compare_field("out_red", want.red, rsp_bus.out_red);
            compare_field("out_green", want.green, rsp_bus.out_green);
            compare_field("out_blue", want.blue, rsp_bus.out_blue);
            compare_field("out_alpha", want.alpha, rsp_bus.out_alpha);
            compare_field("run_last", want.last, rsp_bus.run_last);
         end
      end
   end

   // top row of the reset geometry, all border
   task automatic test_reset_defaults();
      send_pixel(32'h0000_0000);
      send_pixel(32'hFFFF_FFFF);
      stop_pixels();
      wait_drained();
   endtask

   // 3x3 frame whose gradient sum lands exactly on the threshold: no edge
   task automatic test_threshold_boundary();
      logic [PIX_W-1:0] px;
      write_register(CSR_THRESHOLD, 13'd1530);
      write_register(CSR_WIDTH, 13'd3);
      write_register(CSR_HEIGHT, 13'd3);
      for (int y = 0; y < 3; y++) begin
         for (int x = 0; x < 3; x++) begin
            if (x == 1 && y == 1)
               px = 32'h5AFF_FFFF;
            else if (x == 0 || y == 0)
               px = 32'h0000_0000;
            else
               px = 32'hFFFF_FFFF;
            send_pixel(px);
         end
      end
      stop_pixels();
      wait_drained();
   endtask

   // flat frame with one odd corner: only the diagonal sum trips
   task automatic test_diagonal_edge();
      write_register(CSR_THRESHOLD, 13'd0);
      for (int i = 0; i < 9; i++)
         send_pixel(i == 0 ? 32'h8080_8000 : 32'h8080_8080);
      stop_pixels();
      wait_drained();
   endtask

   // zero geometry acts as a single pixel frame; unused index is ignored
   task automatic test_degenerate_geometry();
      write_register(CSR_SPARE, 13'h1FFF);
      write_register(CSR_WIDTH, 13'd0);
      write_register(CSR_HEIGHT, 13'd0);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h0000_0000);
      stop_pixels();
      wait_drained();
   endtask

   // random geometry, threshold and content, one setting per phase
   task automatic test_random_frames(input int target, input bit allow_idle);
      int unsigned frame_px;
      int unsigned burst;
      while (pixels_sent < target) begin
         src_gap_pct   = allow_idle ? idle_share() : 0;
         snk_stall_pct = allow_idle ? idle_share() : 0;

         // geometry writes always restart the frame
         if ($urandom_range(0, 1)) begin
            write_register(CSR_WIDTH, pick_extent());
            write_register(CSR_HEIGHT, pick_extent());
         end else begin
            write_register(CSR_HEIGHT, pick_extent());
            write_register(CSR_WIDTH, pick_extent());
         end
         case ($urandom_range(0, 4))
            0:       write_register(CSR_THRESHOLD, 13'd0);
            1:       write_register(CSR_THRESHOLD, 13'd2047);
            2:       write_register(CSR_THRESHOLD, CSR_DATA_W'($urandom_range(0, 2047)));
            3:       write_register(CSR_THRESHOLD, CSR_DATA_W'($urandom_range(0, 64)));
            default: write_register(CSR_THRESHOLD, CSR_DATA_W'($urandom_range(0, 600)));
         endcase
         if ($urandom_range(0, 7) == 0)
            write_register(CSR_SPARE, CSR_DATA_W'($urandom_range(0, 8191)));

         // image content for this phase
         cur_style  = pixel_style_type'($urandom_range(0, 2));
         base_color = $urandom();
         alt_color  = $urandom();
         noise_mag  = $urandom_range(0, 15);
         split_kind = $urandom_range(0, 2);
         split_pos  = $urandom_range(1, 10);

         // whole frames when they are small, at times with part of one more; a partial frame otherwise
         frame_px = effective_extent(width_reg, FRAME_MAX_W) *
                    effective_extent(height_reg, MAX_HEIGHT);
         if (frame_px > 240) begin
            burst = $urandom_range(1, 240);
         end else begin
            burst = frame_px * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0)
               burst += $urandom_range(1, frame_px);
         end
         // stop at the pixel budget of this stretch
         if (burst > unsigned'(target - pixels_sent))
            burst = unsigned'(target - pixels_sent);
         repeat (burst) send_pixel(make_pixel());
         stop_pixels();
         wait_drained();
      end
   endtask

   // test sequence
   initial begin
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.in_red   <= '0;
      req_bus.in_green <= '0;
      req_bus.in_blue  <= '0;
      req_bus.in_alpha <= '0;
      csr_bus.valid    <= 1'b0;
      csr_bus.index    <= '0;
      csr_bus.data     <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      src_gap_pct   = 20;
      snk_stall_pct = 20;
      test_reset_defaults();
      test_threshold_boundary();
      test_diagonal_edge();
      test_degenerate_geometry();
      test_random_frames(1300, 1'b1);
      // closing stretch at full rate
      test_random_frames(1450, 1'b0);

      wait_drained();
      if (mismatches == 0)
         $display("gradient_edge_blackout_filter regression: pass");
      else
         $display("gradient_edge_blackout_filter regression: fail");
      $finish;
   end

endmodule

`default_nettype wire
